// ----- rtl/toy_isa_execute_unit_core_macros.svh -----
// Assertion macros shared by the execute unit RTL.
`ifndef TOY_ISA_EXECUTE_UNIT_CORE_MACROS_SVH
`define TOY_ISA_EXECUTE_UNIT_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled in reset.
`define TIEXU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("toy_isa_execute_unit_core: same-cycle check failed");

// Next-cycle implication, sampled on clk, disabled in reset.
`define TIEXU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("toy_isa_execute_unit_core: next-cycle check failed");

`endif

// ----- rtl/tiexu_pkg.sv -----
// Shared types and codes of the execute unit.
`default_nettype none

package tiexu_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CMD_W  = 4;
  localparam int unsigned ADDR_W = 10;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 4'd0,
    CMD_NEG    = 4'd1,
    CMD_MULT   = 4'd2,
    CMD_JMP    = 4'd3,
    CMD_JMP0   = 4'd4,
    CMD_LT     = 4'd5,
    CMD_ASSIGN = 4'd6,
    CMD_READ   = 4'd7,
    CMD_WRITE  = 4'd8,
    CMD_HALT   = 4'd9
  } cmd_t;

  typedef enum logic [2:0] {
    ALU_PASS,
    ALU_ADD,
    ALU_NEG,
    ALU_MULT,
    ALU_LT
  } alu_op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_t;

  typedef struct packed {
    alu_op_t           op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] result;
    logic              a_zero;
  } alu_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/tiexu_alu.sv -----
// Shared arithmetic, compare and zero-test unit of the execute unit.
`default_nettype none

module tiexu_alu (
  input  tiexu_pkg::alu_req_t req,
  output tiexu_pkg::alu_rsp_t rsp
);

  always_comb begin
    rsp.a_zero = (req.a == '0);
    unique case (req.op)
      tiexu_pkg::ALU_PASS: rsp.result = req.a;
      tiexu_pkg::ALU_ADD:  rsp.result = req.a + req.b;
      tiexu_pkg::ALU_NEG:  rsp.result = '0 - req.a;
      tiexu_pkg::ALU_MULT: rsp.result = req.a * req.b;
      tiexu_pkg::ALU_LT: begin
        rsp.result = {{(tiexu_pkg::WORD_W-1){1'b0}}, ($signed(req.a) < $signed(req.b))};
      end
      default:             rsp.result = req.a;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/toy_isa_execute_unit_core.sv -----
// Top level of the execute unit: sequencer, data memory, PC, halt flag, result register.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall   | cmd, operands, dest, target, read_data
//   out_    | output    | out_valid / out_stall | next_pc, halted, emit, illegal
//
// An item passes through three steps: accept, data memory read of both operands, execute and write.
// The input register and the registered data memory read lie between the steps.
// After reset a clearing pass zeroes every data memory word; no item is accepted meanwhile.
// A result waits in the output register; the next item is accepted meanwhile and its
// execute step holds until the output register frees.
`default_nettype none
`include "toy_isa_execute_unit_core_macros.svh"

module toy_isa_execute_unit_core #(
  parameter int unsigned DATA_WORDS = 1024,
  parameter int unsigned PROG_WORDS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_cmd,
  input  logic               in_src1_is_addr,
  input  logic signed [31:0] in_src1,
  input  logic               in_src2_is_addr,
  input  logic signed [31:0] in_src2,
  input  logic [9:0]         in_dest,
  input  logic [9:0]         in_target,
  input  logic signed [31:0] in_read_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [9:0]         out_next_pc,
  output logic               out_halted,
  output logic               out_emit_valid,
  output logic signed [31:0] out_emit_value,
  output logic               out_illegal
);

  localparam int unsigned AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int unsigned PW = (PROG_WORDS > 1) ? $clog2(PROG_WORDS) : 1;
  localparam logic [31:0] DATA_LIM = 32'(DATA_WORDS);
  localparam logic [31:0] PROG_LIM = 32'(PROG_WORDS);
  localparam logic [AW-1:0] CLR_LAST = AW'(DATA_WORDS - 1);

  tiexu_pkg::state_t state_r, state_nxt;

  logic [3:0]    cmd_r;
  logic          src1_addr_r, src2_addr_r;
  logic          src1_ok_r, src2_ok_r, dest_ok_r;
  logic [31:0]   src1_r, src2_r, read_data_r;
  logic [9:0]    dest_r, target_r;
  logic [31:0]   rd1_r, rd2_r;
  logic [PW-1:0] pc_r, pc_nxt;
  logic          halt_flag_r, halt_flag_nxt;
  logic [AW-1:0] clr_cnt_r;

  logic          out_valid_r, out_valid_nxt;
  logic [9:0]    out_next_pc_r;
  logic          out_halted_r, out_emit_valid_r, out_illegal_r;
  logic [31:0]   out_emit_value_r;

  logic        in_accept, out_free, rd_en, exec_fire, clearing;
  logic [31:0] op_a, op_b, dest_ext, pc_inc_ext, jump_ext;
  logic [PW-1:0] pc_calc;
  logic        exec_we, exec_emit, exec_bad, exec_halt;
  logic [31:0] exec_wdata;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0] mem_wdata;

  logic [31:0] mem [DATA_WORDS];

  tiexu_pkg::alu_req_t alu_req;
  tiexu_pkg::alu_rsp_t alu_rsp;

  tiexu_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tiexu_pkg::ST_CLEAR: if (clr_cnt_r == CLR_LAST) state_nxt = tiexu_pkg::ST_IDLE;
      tiexu_pkg::ST_IDLE:  if (in_accept) state_nxt = tiexu_pkg::ST_READ;
      tiexu_pkg::ST_READ:  state_nxt = tiexu_pkg::ST_EXEC;
      tiexu_pkg::ST_EXEC:  if (out_free) state_nxt = tiexu_pkg::ST_IDLE;
      default:             state_nxt = tiexu_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    rd_en     = 1'b0;
    exec_fire = 1'b0;
    clearing  = 1'b0;
    unique case (state_r)
      tiexu_pkg::ST_CLEAR: clearing = 1'b1;
      tiexu_pkg::ST_IDLE:  in_stall = 1'b0;
      tiexu_pkg::ST_READ:  rd_en = 1'b1;
      tiexu_pkg::ST_EXEC:  exec_fire = out_free;
      default:             in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tiexu_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      pc_r        <= '0;
      halt_flag_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clearing ? clr_cnt_r + AW'(1) : '0;
      pc_r        <= pc_nxt;
      halt_flag_r <= halt_flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the item
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r       <= in_cmd;
      src1_addr_r <= in_src1_is_addr;
      src2_addr_r <= in_src2_is_addr;
      src1_r      <= in_src1;
      src2_r      <= in_src2;
      src1_ok_r   <= $unsigned(in_src1) < DATA_LIM;
      src2_ok_r   <= $unsigned(in_src2) < DATA_LIM;
      dest_r      <= in_dest;
      dest_ok_r   <= 32'(in_dest) < DATA_LIM;
      target_r    <= in_target;
      read_data_r <= in_read_data;
    end
  end

  // data memory
  assign dest_ext  = 32'(dest_r);
  assign mem_we    = clearing || (exec_fire && exec_we && dest_ok_r);
  assign mem_waddr = clearing ? clr_cnt_r : dest_ext[AW-1:0];
  assign mem_wdata = clearing ? '0 : exec_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (rd_en) begin
      rd1_r <= mem[src1_r[AW-1:0]];
      rd2_r <= mem[src2_r[AW-1:0]];
    end
  end

  // execute
  assign op_a = src1_addr_r ? (src1_ok_r ? rd1_r : '0) : src1_r;
  assign op_b = src2_addr_r ? (src2_ok_r ? rd2_r : '0) : src2_r;

  assign pc_inc_ext = 32'(pc_r) + 32'd1;
  assign jump_ext   = (32'(target_r) < PROG_LIM) ? 32'(target_r) : '0;

  always_comb begin
    alu_req.op = tiexu_pkg::ALU_PASS;
    alu_req.a  = op_a;
    alu_req.b  = op_b;
    pc_calc    = (pc_inc_ext >= PROG_LIM) ? '0 : pc_inc_ext[PW-1:0];
    exec_we    = 1'b0;
    exec_emit  = 1'b0;
    exec_bad   = 1'b0;
    exec_halt  = 1'b0;
    exec_wdata = alu_rsp.result;
    unique case (cmd_r)
      tiexu_pkg::CMD_ADD: begin
        alu_req.op = tiexu_pkg::ALU_ADD;
        exec_we    = 1'b1;
      end
      tiexu_pkg::CMD_NEG: begin
        alu_req.op = tiexu_pkg::ALU_NEG;
        exec_we    = 1'b1;
      end
      tiexu_pkg::CMD_MULT: begin
        alu_req.op = tiexu_pkg::ALU_MULT;
        exec_we    = 1'b1;
      end
      tiexu_pkg::CMD_JMP: pc_calc = jump_ext[PW-1:0];
      tiexu_pkg::CMD_JMP0: if (alu_rsp.a_zero) pc_calc = jump_ext[PW-1:0];
      tiexu_pkg::CMD_LT: begin
        alu_req.op = tiexu_pkg::ALU_LT;
        exec_we    = 1'b1;
      end
      tiexu_pkg::CMD_ASSIGN: exec_we = 1'b1;
      tiexu_pkg::CMD_READ: begin
        exec_we    = 1'b1;
        exec_wdata = read_data_r;
      end
      tiexu_pkg::CMD_WRITE: exec_emit = 1'b1;
      tiexu_pkg::CMD_HALT:  exec_halt = 1'b1;
      default:              exec_bad = 1'b1;
    endcase
    // drop everything once halted
    if (halt_flag_r) begin
      pc_calc   = pc_r;
      exec_we   = 1'b0;
      exec_emit = 1'b0;
      exec_bad  = 1'b0;
      exec_halt = 1'b0;
    end
  end

  assign pc_nxt        = exec_fire ? pc_calc : pc_r;
  assign halt_flag_nxt = halt_flag_r || (exec_fire && exec_halt);
  assign out_valid_nxt = exec_fire ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_next_pc_r    <= 10'(32'(pc_calc));
      out_halted_r     <= halt_flag_r || exec_halt;
      out_emit_valid_r <= exec_emit;
      out_emit_value_r <= exec_emit ? op_a : '0;
      out_illegal_r    <= exec_bad;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_next_pc    = out_next_pc_r;
  assign out_halted     = out_halted_r;
  assign out_emit_valid = out_emit_valid_r;
  assign out_emit_value = out_emit_value_r;
  assign out_illegal    = out_illegal_r;

  `TIEXU_ASSERT_NEXT(a_accept_reads, in_accept, state_r == tiexu_pkg::ST_READ)
  `TIEXU_ASSERT_SAME(a_halt_no_write, halt_flag_r && !clearing, !mem_we)
  `TIEXU_ASSERT_SAME(a_emit_zero, out_valid_r && !out_emit_valid_r, out_emit_value_r == '0)
  `TIEXU_ASSERT_SAME(a_halt_clean, out_valid_r && out_halted_r,
                     !out_illegal_r && !out_emit_valid_r)
  `TIEXU_ASSERT_SAME(a_clear_quiet, clearing, !out_valid_r && in_stall)

endmodule

`default_nettype wire
